>>> hdl/dcmi_pkg.sv
// Shared types, constants and register map of the damage colormap interpolator.
`default_nettype none

package dcmi_pkg;

    localparam int REG_ENTRIES     = 4;
    localparam int PALETTE_ENTRIES = 4;
    localparam int USED_ENTRIES    = (PALETTE_ENTRIES < 2) ? 2 :
                                     ((PALETTE_ENTRIES > REG_ENTRIES) ? REG_ENTRIES :
                                      PALETTE_ENTRIES);

    localparam int BRK_W      = 15;
    localparam int COL_W      = 24;
    localparam int CH_W       = 8;
    localparam int CHANNELS   = 3;
    localparam int SEG_W      = 2;
    localparam int IDX_W      = 2;
    localparam int DAMAGE_W   = 16;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_STAGES = DIV_STEPS + 1;
    localparam int FRAC_W     = DIV_STEPS + 1;
    localparam int PROD_W     = 26;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 32;

    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(USED_ENTRIES - 2);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(USED_ENTRIES - 1);

    typedef logic [BRK_W-1:0]  brk_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [FRAC_W-1:0] frac_t;

    localparam brk_t BRK_RST [REG_ENTRIES] = '{15'd0, 15'd4096, 15'd6144, 15'd8192};
    localparam col_t COL_RST [REG_ENTRIES] = '{24'hF2F2F2, 24'h999999, 24'h404040, 24'h0000FF};

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [IDX_W-1:0] cidx;
        logic             clip;
    } meta_t;

    typedef enum logic [2:0] {
        REG_BREAK_ZERO   = 3'd0,
        REG_BREAK_ONE    = 3'd1,
        REG_BREAK_TWO    = 3'd2,
        REG_BREAK_THREE  = 3'd3,
        REG_COLOUR_ZERO  = 3'd4,
        REG_COLOUR_ONE   = 3'd5,
        REG_COLOUR_TWO   = 3'd6,
        REG_COLOUR_THREE = 3'd7
    } reg_idx_t;

endpackage

`default_nettype wire

>>> hdl/dcmi_div.sv
// Pipelined restoring divider producing the 17-bit segment fraction, one bit per stage.
`default_nettype none

module dcmi_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire dcmi_pkg::brk_t             in_x,
    input  wire dcmi_pkg::brk_t             in_span,
    input  wire dcmi_pkg::meta_t            in_meta,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output dcmi_pkg::frac_t                 out_frac,
    output dcmi_pkg::meta_t                 out_meta
);

    localparam int N = dcmi_pkg::DIV_STAGES;
    localparam int W = dcmi_pkg::BRK_W;

    logic [N-1:0]        vld_reg;
    logic [N:0]          adv;
    dcmi_pkg::brk_t      rem_reg  [N];
    dcmi_pkg::brk_t      span_reg [N];
    dcmi_pkg::frac_t     quo_reg  [N];
    dcmi_pkg::meta_t     meta_reg [N];
    dcmi_pkg::brk_t      rem_next [N];
    dcmi_pkg::frac_t     quo_next [N];

    always_comb begin
        adv[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_comb begin
        logic [W:0] rs;
        logic       ge;
        rs = '0;
        ge = 1'b0;
        // integer bit: x never exceeds span
        ge = (in_x >= in_span);
        rem_next[0] = ge ? (in_x - in_span) : in_x;
        quo_next[0] = {{dcmi_pkg::DIV_STEPS{1'b0}}, ge};
        for (int k = 1; k < N; k++) begin
            rs = {rem_reg[k-1], 1'b0};
            ge = (rs >= {1'b0, span_reg[k-1]});
            rem_next[k] = ge ? W'(rs - {1'b0, span_reg[k-1]}) : rs[W-1:0];
            quo_next[k] = {quo_reg[k-1][dcmi_pkg::FRAC_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            span_reg[0] <= in_span;
            meta_reg[0] <= in_meta;
        end
        for (int k = 0; k < N; k++) begin
            if (adv[k]) begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
        for (int k = 1; k < N; k++) begin
            if (adv[k]) begin
                span_reg[k] <= span_reg[k-1];
                meta_reg[k] <= meta_reg[k-1];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign out_frac  = quo_reg[N-1];
    assign out_meta  = meta_reg[N-1];

    a_frac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (!out_frac[dcmi_pkg::FRAC_W-1] ||
                       (out_frac[dcmi_pkg::FRAC_W-2:0] == '0)))
        else $error("fraction exceeds one");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (rem_reg[N-1] < span_reg[N-1]))
        else $error("remainder not below divisor");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_frac)))
        else $error("divider output lost under stall");

endmodule

`default_nettype wire

>>> hdl/damage_colormap_interpolator.sv
// Top level: piecewise-linear colormap of a Q2.13 damage stream to RGB.
//
// Input channel s_*: one signed Q2.13 damage value per transfer in s_tdata.
// Output channel m_*: red, green, blue and segment index in m_tdata, the
// clipped flag in m_tuser. One result per input, in order.
// Configuration: APB write of breakpoints (byte 0x00..0x0C) and RGB colors
// (0x10..0x1C); change only while the pipeline is empty.
// Pipeline: 21 register stages: clamp and compare, span subtract, a 17-stage
// divider (one fraction bit per stage), blend multiply, blend add into the
// output register.
// Throughput: one item per cycle while m_tready is high; every stage is a
// register with its own valid bit, so any stage takes a new item while the
// one ahead moves or is empty.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads the
// default palette.
// Stall: while m_tready is low the output holds; bubbles ahead of it are
// filled, and s_tready drops only when every stage holds an item.
`default_nettype none

module damage_colormap_interpolator (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [dcmi_pkg::TDATA_IN_W-1:0]      s_tdata,   // [15:0] damage
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [25:24] segment, [31:26] zero
    output logic [dcmi_pkg::TDATA_OUT_W-1:0]          m_tdata,
    output logic                                      m_tuser,   // [0] clipped
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [dcmi_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [dcmi_pkg::DATA_W-1:0]          pwdata,
    output logic [dcmi_pkg::DATA_W-1:0]               prdata,
    output logic                                      pready
);

    localparam int RE = dcmi_pkg::REG_ENTRIES;
    localparam int UE = dcmi_pkg::USED_ENTRIES;
    localparam int BW = dcmi_pkg::BRK_W;
    localparam int CW = dcmi_pkg::CH_W;
    localparam int PW = dcmi_pkg::PROD_W;

    dcmi_pkg::brk_t brk_reg [RE];
    dcmi_pkg::col_t col_reg [RE];

    logic               cfg_wr;
    dcmi_pkg::reg_idx_t cfg_idx;
    dcmi_pkg::reg_idx_t rd_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = dcmi_pkg::reg_idx_t'(paddr[dcmi_pkg::ADDR_W-1:2]);
    assign rd_idx  = dcmi_pkg::reg_idx_t'(paddr[dcmi_pkg::ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RE; i++) begin
                brk_reg[i] <= dcmi_pkg::BRK_RST[i];
                col_reg[i] <= dcmi_pkg::COL_RST[i];
            end
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dcmi_pkg::REG_BREAK_ZERO:   brk_reg[0] <= pwdata[BW-1:0];
                dcmi_pkg::REG_BREAK_ONE:    brk_reg[1] <= pwdata[BW-1:0];
                dcmi_pkg::REG_BREAK_TWO:    brk_reg[2] <= pwdata[BW-1:0];
                dcmi_pkg::REG_BREAK_THREE:  brk_reg[3] <= pwdata[BW-1:0];
                dcmi_pkg::REG_COLOUR_ZERO:  col_reg[0] <= pwdata[dcmi_pkg::COL_W-1:0];
                dcmi_pkg::REG_COLOUR_ONE:   col_reg[1] <= pwdata[dcmi_pkg::COL_W-1:0];
                dcmi_pkg::REG_COLOUR_TWO:   col_reg[2] <= pwdata[dcmi_pkg::COL_W-1:0];
                dcmi_pkg::REG_COLOUR_THREE: col_reg[3] <= pwdata[dcmi_pkg::COL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (rd_idx)
            dcmi_pkg::REG_BREAK_ZERO:   prdata = dcmi_pkg::DATA_W'(brk_reg[0]);
            dcmi_pkg::REG_BREAK_ONE:    prdata = dcmi_pkg::DATA_W'(brk_reg[1]);
            dcmi_pkg::REG_BREAK_TWO:    prdata = dcmi_pkg::DATA_W'(brk_reg[2]);
            dcmi_pkg::REG_BREAK_THREE:  prdata = dcmi_pkg::DATA_W'(brk_reg[3]);
            dcmi_pkg::REG_COLOUR_ZERO:  prdata = dcmi_pkg::DATA_W'(col_reg[0]);
            dcmi_pkg::REG_COLOUR_ONE:   prdata = dcmi_pkg::DATA_W'(col_reg[1]);
            dcmi_pkg::REG_COLOUR_TWO:   prdata = dcmi_pkg::DATA_W'(col_reg[2]);
            dcmi_pkg::REG_COLOUR_THREE: prdata = dcmi_pkg::DATA_W'(col_reg[3]);
        endcase
    end

    // ---------------- pipeline control
    logic adv_s1, adv_s2, adv_mul, adv_out;
    logic s1_vld_reg, s2_vld_reg, mul_vld_reg, m_vld_reg;
    logic div_in_ready, div_out_valid;

    assign adv_out  = !m_vld_reg || m_tready;
    assign adv_mul  = !mul_vld_reg || adv_out;
    assign adv_s2   = !s2_vld_reg || div_in_ready;
    assign adv_s1   = !s1_vld_reg || adv_s2;
    assign s_tready = adv_s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            if (adv_s1)  s1_vld_reg  <= s_tvalid;
            if (adv_s2)  s2_vld_reg  <= s1_vld_reg;
            if (adv_mul) mul_vld_reg <= div_out_valid;
            if (adv_out) m_vld_reg   <= mul_vld_reg;
        end
    end

    // ---------------- stage 1: clamp and locate segment
    dcmi_pkg::brk_t  d_clamp;
    logic [RE-1:0]   le;
    logic            is_first, is_last;
    dcmi_pkg::meta_t s1_meta_next;
    dcmi_pkg::brk_t  s1_d_reg;
    dcmi_pkg::meta_t s1_meta_reg;
    logic            s1_sat_reg;

    always_comb begin
        logic [dcmi_pkg::SEG_W-1:0] mid_seg;
        d_clamp = s_tdata[dcmi_pkg::DAMAGE_W-1] ? '0 : s_tdata[BW-1:0];
        for (int i = 0; i < RE; i++) begin
            le[i] = (d_clamp <= brk_reg[i]);
        end
        is_first = le[0];
        is_last  = !le[UE-1];
        mid_seg  = dcmi_pkg::SEG_LAST;
        for (int i = UE - 2; i >= 1; i--) begin
            if (le[i]) mid_seg = dcmi_pkg::SEG_W'(i - 1);
        end
        priority if (is_first) begin
            s1_meta_next.seg  = '0;
            s1_meta_next.cidx = '0;
            s1_meta_next.clip = (d_clamp < brk_reg[0]);
        end else if (is_last) begin
            s1_meta_next.seg  = dcmi_pkg::SEG_LAST;
            s1_meta_next.cidx = dcmi_pkg::IDX_LAST;
            s1_meta_next.clip = 1'b1;
        end else begin
            s1_meta_next.seg  = mid_seg;
            s1_meta_next.cidx = dcmi_pkg::IDX_W'(mid_seg);
            s1_meta_next.clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_s1) begin
            s1_d_reg    <= d_clamp;
            s1_meta_reg <= s1_meta_next;
            s1_sat_reg  <= is_first || is_last;
        end
    end

    // ---------------- stage 2: offset and span of the segment
    dcmi_pkg::brk_t  lo_sel, hi_sel;
    dcmi_pkg::brk_t  s2_x_reg, s2_span_reg;
    dcmi_pkg::meta_t s2_meta_reg;
    logic [dcmi_pkg::IDX_W-1:0] s1_hi_idx;

    assign s1_hi_idx = dcmi_pkg::IDX_W'(s1_meta_reg.seg) + dcmi_pkg::IDX_W'(1);

    always_comb begin
        lo_sel = '0;
        hi_sel = '0;
        for (int i = 0; i < RE; i++) begin
            lo_sel = lo_sel | ((dcmi_pkg::IDX_W'(s1_meta_reg.seg) == dcmi_pkg::IDX_W'(i))
                               ? brk_reg[i] : '0);
            hi_sel = hi_sel | ((s1_hi_idx == dcmi_pkg::IDX_W'(i)) ? brk_reg[i] : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_s2) begin
            // saturated items divide zero by one
            s2_x_reg    <= s1_sat_reg ? '0 : (s1_d_reg - lo_sel);
            s2_span_reg <= s1_sat_reg ? BW'(1) : (hi_sel - lo_sel);
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // ---------------- divider
    dcmi_pkg::frac_t div_frac;
    dcmi_pkg::meta_t div_meta;

    dcmi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_vld_reg),
        .in_ready  (div_in_ready),
        .in_x      (s2_x_reg),
        .in_span   (s2_span_reg),
        .in_meta   (s2_meta_reg),
        .out_valid (div_out_valid),
        .out_ready (adv_mul),
        .out_frac  (div_frac),
        .out_meta  (div_meta)
    );

    // ---------------- blend multiply
    dcmi_pkg::col_t  start_col, end_col;
    logic [dcmi_pkg::IDX_W-1:0] div_end_idx;
    logic signed [PW:0]  prod_full [dcmi_pkg::CHANNELS];
    logic signed [PW-1:0] prod_reg [dcmi_pkg::CHANNELS];
    dcmi_pkg::col_t  mul_start_reg;
    dcmi_pkg::meta_t mul_meta_reg;

    assign div_end_idx = dcmi_pkg::IDX_W'(div_meta.seg) + dcmi_pkg::IDX_W'(1);

    always_comb begin
        logic signed [CW:0] diff;
        diff      = '0;
        start_col = '0;
        end_col   = '0;
        for (int i = 0; i < RE; i++) begin
            start_col = start_col | ((div_meta.cidx == dcmi_pkg::IDX_W'(i)) ? col_reg[i] : '0);
            end_col   = end_col | ((div_end_idx == dcmi_pkg::IDX_W'(i)) ? col_reg[i] : '0);
        end
        for (int c = 0; c < dcmi_pkg::CHANNELS; c++) begin
            diff = $signed({1'b0, end_col[c*CW +: CW]}) - $signed({1'b0, start_col[c*CW +: CW]});
            prod_full[c] = $signed({1'b0, div_frac}) * diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_mul) begin
            for (int c = 0; c < dcmi_pkg::CHANNELS; c++) begin
                prod_reg[c] <= prod_full[c][PW-1:0];
            end
            mul_start_reg <= start_col;
            mul_meta_reg  <= div_meta;
        end
    end

    // ---------------- blend add and output register
    logic [dcmi_pkg::COL_W-1:0] rgb_next;
    logic [dcmi_pkg::COL_W-1:0] rgb_reg;
    logic [dcmi_pkg::SEG_W-1:0] seg_reg;
    logic                       clip_reg;

    always_comb begin
        logic [CW+1:0] sum;
        sum = '0;
        for (int c = 0; c < dcmi_pkg::CHANNELS; c++) begin
            sum = {2'b00, mul_start_reg[c*CW +: CW]} + prod_reg[c][PW-1:16];
            rgb_next[c*CW +: CW] = sum[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out) begin
            rgb_reg  <= rgb_next;
            seg_reg  <= mul_meta_reg.seg;
            clip_reg <= mul_meta_reg.clip;
        end
    end

    // rgb_reg keeps the palette order: red in the top byte, blue in the bottom byte
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(dcmi_pkg::TDATA_OUT_W - dcmi_pkg::COL_W - dcmi_pkg::SEG_W){1'b0}},
                       seg_reg, rgb_reg[7:0], rgb_reg[15:8], rgb_reg[23:16]};
    assign m_tuser  = clip_reg;

    a_span_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_vld_reg |-> ((s2_span_reg != '0) && (s2_x_reg <= s2_span_reg)))
        else $error("segment offset outside span");

    a_clip_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata[25:24] == '0) ||
                                    (m_tdata[25:24] == dcmi_pkg::SEG_LAST)))
        else $error("clipped item in an inner segment");

    a_sat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_out_valid && div_meta.clip) |-> (div_frac == '0))
        else $error("saturated item with nonzero fraction");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
